[hw/rtl/psh_pkg.sv]
// Package for the PS/2 host link shifter: event kinds, status and drive codes,
// frame constants and the item and result structures.
// No dependencies; every other file of the block imports it.
package psh_pkg;

    localparam int unsigned FRAME_W = 12;
    localparam int unsigned TICK_W  = 8;

    localparam logic [FRAME_W-1:0] RX_MARKER   = 12'h800;
    localparam logic [FRAME_W-1:0] RX_PARMASK  = 12'h7fc;
    localparam logic [FRAME_W-1:0] TX_HIGHBITS = 12'h600;
    localparam logic [FRAME_W-1:0] PARITY_BIT  = 12'h100;
    localparam logic [7:0]         BYTE_MASK   = 8'hff;
    localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 8'd10;

    typedef enum logic [1:0] {
        KIND_EDGE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_SEND = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_RX_BYTE     = 3'd1,
        ST_RX_DROP     = 3'd2,
        ST_SEND_OK     = 3'd3,
        ST_SEND_REFUSE = 3'd4,
        ST_TX_DONE     = 3'd5,
        ST_TIMEOUT     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        DRV_LEAVE   = 2'd0,
        DRV_LOW     = 2'd1,
        DRV_RELEASE = 2'd2
    } drive_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       data_line;
        logic [7:0] tx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] rx_byte;
        logic [1:0] data_drive;
        logic       clock_inhibit;
        logic       clock_release;
    } result_t;

endpackage

[hw/rtl/psh_core.sv]
// Link state of the PS/2 host shifter: transmit and receive shifters, idle timeout,
// and the single-pass logic that turns one event into one result.
// Depends on psh_pkg.
module psh_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  psh_pkg::item_t                   item,
    input  logic [psh_pkg::TICK_W-1:0]       timeout_ticks,
    output psh_pkg::result_t                 result
);
    import psh_pkg::*;

    logic [FRAME_W-1:0] tx_shift_reg, tx_shift_next;
    logic [FRAME_W-1:0] rx_shift_reg, rx_shift_next;
    logic [TICK_W-1:0]  timeout_count_reg, timeout_count_next;

    logic [FRAME_W-1:0] rx_work;
    logic [FRAME_W-1:0] rx_after;
    logic [FRAME_W-1:0] tx_word;
    logic               rx_active;

    always_comb
    begin
        tx_shift_next      = tx_shift_reg;
        rx_shift_next      = rx_shift_reg;
        timeout_count_next = timeout_count_reg;
        result             = '0;
        rx_active          = 1'b0;
        rx_work            = rx_shift_reg;
        rx_after           = '0;
        // Odd parity: the parity bit is set when the data byte has an even count of ones.
        tx_word = {4'b0000, item.tx_byte} | ((^item.tx_byte) ? '0 : PARITY_BIT);
        tx_word = tx_word | TX_HIGHBITS;

        case (item.kind)
            KIND_EDGE:
            begin
                timeout_count_next = timeout_ticks;
                if (rx_shift_reg == '0)
                begin
                    if (tx_shift_reg == {{(FRAME_W-1){1'b0}}, 1'b1})
                    begin
                        tx_shift_next      = '0;
                        timeout_count_next = '0;
                        result.status      = ST_TX_DONE;
                    end
                    else if (tx_shift_reg != '0)
                    begin
                        result.data_drive = tx_shift_reg[0] ? DRV_RELEASE : DRV_LOW;
                        tx_shift_next     = {1'b0, tx_shift_reg[FRAME_W-1:1]};
                    end
                    else
                    begin
                        // Both shifters idle: this edge carries the start bit.
                        rx_active = 1'b1;
                        rx_work   = RX_MARKER;
                    end
                end
                else
                begin
                    rx_active = 1'b1;
                end

                if (rx_active)
                begin
                    rx_after      = {item.data_line, rx_work[FRAME_W-1:1]};
                    rx_shift_next = rx_after;
                    // The marker has reached bit 0 once all eleven bits are in.
                    if (rx_after[0])
                    begin
                        if (((rx_after & RX_MARKER) != '0) && (^(rx_after & RX_PARMASK)))
                        begin
                            result.status  = ST_RX_BYTE;
                            result.rx_byte = rx_after[9:2] & BYTE_MASK;
                        end
                        else
                        begin
                            result.status = ST_RX_DROP;
                        end
                        rx_shift_next      = '0;
                        timeout_count_next = '0;
                    end
                end
            end
            KIND_TICK:
            begin
                if (timeout_count_reg > 8'd1)
                begin
                    timeout_count_next = timeout_count_reg - 8'd1;
                end
                else if (timeout_count_reg == 8'd1)
                begin
                    tx_shift_next        = '0;
                    rx_shift_next        = '0;
                    timeout_count_next   = '0;
                    result.data_drive    = DRV_RELEASE;
                    result.clock_release = 1'b1;
                    result.status        = ST_TIMEOUT;
                end
            end
            KIND_SEND:
            begin
                if (rx_shift_reg != '0)
                begin
                    result.status = ST_SEND_REFUSE;
                end
                else
                begin
                    tx_shift_next        = {tx_word[FRAME_W-2:0], 1'b0};
                    timeout_count_next   = '0;
                    result.data_drive    = DRV_LOW;
                    result.clock_inhibit = 1'b1;
                    result.status        = ST_SEND_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg      <= '0;
            rx_shift_reg      <= '0;
            timeout_count_reg <= '0;
        end
        else if (fire)
        begin
            tx_shift_reg      <= tx_shift_next;
            rx_shift_reg      <= rx_shift_next;
            timeout_count_reg <= timeout_count_next;
        end
    end

    // A receive only starts with the transmitter idle, and a send is refused during one.
    a_shifters_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((rx_shift_reg != '0) && (tx_shift_reg != '0)))
        else $error("transmit and receive shifters active together");

    // A finished receive frame is cleared in the same pass, so the marker never rests in bit 0.
    a_rx_marker_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        rx_shift_reg[0] == 1'b0)
        else $error("receive shifter left holding a complete frame");

    a_send_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (result.status == ST_SEND_OK)) |=>
            ((timeout_count_reg == '0) && (tx_shift_reg[FRAME_W-1] == 1'b1)))
        else $error("accepted send did not load frame and disarm timeout");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (result.status == ST_TIMEOUT)) |=>
            ((tx_shift_reg == '0) && (rx_shift_reg == '0)))
        else $error("timeout abort left a shifter running");

endmodule

[hw/rtl/ps2_host_link_shifter_unit.sv]
// Top level of the PS/2 host link shifter: input register, configuration register
// and result register around psh_core.
// Depends on psh_pkg and psh_core.
//
// Usage: each event (clock falling edge, 1 ms tick or send request) is offered on
// the item channel (item_valid, item_stall, kind, data_line, tx_byte). Every event
// gives exactly one result on the result channel (result_valid, result_stall,
// status, rx_byte, data_drive, clock_inhibit, clock_release).
// The result is registered after its item transfer; one item is accepted every
// cycle while result_stall does not hold the result register, set by the single
// pass through the shifter logic between the input register and the result register.
// When the receiver stalls, the result register holds its value and the input
// register keeps one more item; item_stall rises only when both are occupied.
// Reset empties both registers, idles the shifters, disarms the timeout and sets
// the timeout register to ten ticks. The user writes the timeout register with cfg_we
// and cfg_data only while no event is in flight; the block does not enforce it.
module ps2_host_link_shifter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  kind,
    input  logic                        data_line,
    input  logic [7:0]                  tx_byte,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [2:0]                  status,
    output logic [7:0]                  rx_byte,
    output logic [1:0]                  data_drive,
    output logic                        clock_inhibit,
    output logic                        clock_release,
    input  logic                        cfg_we,
    input  logic [psh_pkg::TICK_W-1:0]  cfg_data
);
    import psh_pkg::*;

    item_t             item_reg;
    logic              item_valid_reg, item_valid_next;
    result_t           result_reg;
    result_t           core_result;
    logic              result_valid_reg, result_valid_next;
    logic [TICK_W-1:0] timeout_ticks_reg;
    logic              accept;
    logic              advance;

    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                timeout_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind      <= kind;
            item_reg.data_line <= data_line;
            item_reg.tx_byte   <= tx_byte;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    psh_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (item_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (core_result)
    );

    assign result_valid  = result_valid_reg;
    assign status        = result_reg.status;
    assign rx_byte       = result_reg.rx_byte;
    assign data_drive    = result_reg.data_drive;
    assign clock_inhibit = result_reg.clock_inhibit;
    assign clock_release = result_reg.clock_release;

endmodule
